>>> src/stt_pkg.sv
package stt_pkg;

    localparam int STRING_LIMIT_DEF  = 256;
    localparam int IDENT_LIMIT_DEF   = 64;
    localparam int NUMBER_LIMIT_DEF  = 64;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;
    localparam int KW_COUNT          = 40;
    localparam int KW_MAX_LEN        = 9;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_PEND, MODE_IDENT, MODE_NUMBER, MODE_STRING,
        MODE_ESC, MODE_LINEC, MODE_BLOCK, MODE_BLOCKGT
    } lex_mode_t;

    localparam logic [2:0] REC_VALUE   = 3'd0;
    localparam logic [2:0] REC_TOKEN   = 3'd1;
    localparam logic [2:0] REC_UNKNOWN = 3'd2;
    localparam logic [2:0] REC_OPENSTR = 3'd3;
    localparam logic [2:0] REC_OPENCMT = 3'd4;

    localparam logic [6:0] K_INT    = 7'd0;
    localparam logic [6:0] K_DNUM   = 7'd1;
    localparam logic [6:0] K_STRING = 7'd2;
    localparam logic [6:0] K_KW0    = 7'd3;
    localparam logic [6:0] K_IDENT  = 7'd43;
    localparam logic [6:0] K_END    = 7'd71;
    localparam logic [6:0] K_NONE   = 7'd127;

    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_NL    = 8'h0a;

    typedef struct packed {
        logic [2:0]  rtype;
        logic [6:0]  kind;
        logic [7:0]  vchar;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  len;
        logic        trunc;
    } rec_t;

    typedef struct packed {
        rec_t [2:0] recs;
        logic [1:0] count;
    } bundle_t;

    // words padded with spaces; the length table bounds the compare
    localparam logic [KW_MAX_LEN-1:0][7:0] KW_TEXT [KW_COUNT] = '{
        "correct  ", "incorrect", "emp      ",
        {8'h72, 8'h69, 8'h76, 8'h65, 8'h6e, "    "},
        "core     ", "firm     ", "craft    ", "returns  ", "if       ",
        "altif    ", "else     ", "flow     ", "during   ", "frame    ",
        "boot     ", "spawn    ", "open     ", "hidden   ", "consistof",
        "resc     ", "attack   ", "spark    ", "sync     ", "bind     ",
        "ref      ", "ptr      ", "raw      ", "rise     ", "drop     ",
        "and      ", "or       ", "not      ", "rec      ", "coll     ",
        "int      ", "dnum     ", "txt      ", "fetch    ", "stamp    ",
        "grab     "
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd9, 4'd3, 4'd5, 4'd4, 4'd4, 4'd5, 4'd7, 4'd2, 4'd5,
        4'd4, 4'd4, 4'd6, 4'd5, 4'd4, 4'd5, 4'd4, 4'd6, 4'd9, 4'd4,
        4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd3,
        4'd2, 4'd3, 4'd3, 4'd4, 4'd3, 4'd4, 4'd3, 4'd5, 4'd5, 4'd4
    };

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_opchar(input logic [7:0] c);
        return c inside {CH_TILDE, CH_LT, "+", "-", "=", "!", CH_GT, "&", "|", CH_DOT};
    endfunction

    function automatic logic [6:0] single_kind(input logic [7:0] c);
        case (c)
            "*": return 7'd53;
            "/": return 7'd54;
            "%": return 7'd55;
            ",": return 7'd62;
            ":": return 7'd63;
            ";": return 7'd64;
            "{": return 7'd65;
            "}": return 7'd66;
            "(": return 7'd67;
            ")": return 7'd68;
            "[": return 7'd69;
            "]": return 7'd70;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [6:0] alone_kind(input logic [7:0] p);
        case (p)
            CH_LT:  return 7'd47;
            CH_GT:  return 7'd48;
            "=":    return 7'd44;
            "!":    return 7'd60;
            "+":    return 7'd51;
            "-":    return 7'd52;
            CH_DOT: return 7'd61;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        if (p == CH_LT && c == "=") return 7'd49;
        if (p == CH_GT && c == "=") return 7'd50;
        if (p == "=" && c == "=") return 7'd45;
        if (p == "!" && c == "=") return 7'd46;
        if (p == "+" && c == CH_GT) return 7'd56;
        if (p == "-" && c == CH_LT) return 7'd57;
        if (p == "&" && c == "&") return 7'd58;
        if (p == "|" && c == "|") return 7'd59;
        return K_NONE;
    endfunction

    function automatic rec_t mk_rec(input logic [2:0] rtype, input logic [6:0] kind,
                                    input logic [7:0] vchar, input logic [15:0] line,
                                    input logic [15:0] col, input logic [7:0] len,
                                    input logic trunc);
        rec_t r;
        r.rtype = rtype;
        r.kind  = kind;
        r.vchar = vchar;
        r.line  = line;
        r.col   = col;
        r.len   = len;
        r.trunc = trunc;
        return r;
    endfunction

endpackage

>>> src/stt_front.sv
module stt_front #(
    parameter int STRING_LIMIT  = stt_pkg::STRING_LIMIT_DEF,
    parameter int IDENT_LIMIT   = stt_pkg::IDENT_LIMIT_DEF,
    parameter int NUMBER_LIMIT  = stt_pkg::NUMBER_LIMIT_DEF,
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [7:0]       in_ch,
    input  logic             in_eos,
    input  logic             space_ok,
    output logic             push,
    output stt_pkg::bundle_t push_data
);
    import stt_pkg::*;

    localparam logic [POSITION_BITS-1:0] PMAX = '1;
    localparam logic [8:0] LIM_STR = 9'(STRING_LIMIT);
    localparam logic [8:0] LIM_ID  = 9'(IDENT_LIMIT);
    localparam logic [8:0] LIM_NUM = 9'(NUMBER_LIMIT);

    lex_mode_t mode_reg, mode_next;
    logic [7:0] pend_reg, pend_next;
    logic [POSITION_BITS-1:0] line_reg, line_next, col_reg, col_next;
    logic [POSITION_BITS-1:0] tl_reg, tl_next, tc_reg, tc_next;
    logic [7:0] vc_reg, vc_next;
    logic [KW_COUNT-1:0] kw_reg, kw_next;
    logic dec_reg, dec_next, ovf_reg, ovf_next;

    logic accept;
    rec_t [2:0] recs;
    logic [1:0] n;
    logic do_start, push_en, push_ident;
    logic [7:0] push_c;
    logic [8:0] push_lim;
    logic [6:0] kind;

    assign accept = in_valid && space_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pend_reg <= '0;
            line_reg <= POSITION_BITS'(1);
            col_reg  <= POSITION_BITS'(1);
            tl_reg   <= '0;
            tc_reg   <= '0;
            vc_reg   <= '0;
            kw_reg   <= '1;
            dec_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tl_reg   <= tl_next;
            tc_reg   <= tc_next;
            vc_reg   <= vc_next;
            kw_reg   <= kw_next;
            dec_reg  <= dec_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        line_next = line_reg;
        col_next  = col_reg;
        tl_next   = tl_reg;
        tc_next   = tc_reg;
        vc_next   = vc_reg;
        kw_next   = kw_reg;
        dec_next  = dec_reg;
        ovf_next  = ovf_reg;
        recs      = '0;
        n         = 2'd0;
        do_start  = 1'b0;
        push_en   = 1'b0;
        push_ident = 1'b0;
        push_c    = in_ch;
        push_lim  = LIM_STR;
        kind      = K_IDENT;

        // word finish kind: INT or DNUM for numbers; else the lowest-index keyword candidate of matching length
        if (mode_reg == MODE_NUMBER) begin
            kind = dec_reg ? K_DNUM : K_INT;
        end else if (!ovf_reg) begin
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                if (kw_reg[i] && {4'd0, KW_LEN[i]} == vc_reg) begin
                    kind = K_KW0 + 7'(i);
                end
            end
        end

        if (in_eos) begin
            case (mode_reg)
                MODE_PEND: begin
                    if (alone_kind(pend_reg) != K_NONE) begin
                        recs[n] = mk_rec(REC_TOKEN, alone_kind(pend_reg), 8'd0,
                                         16'(tl_reg), 16'(tc_reg), 8'd0, 1'b0);
                    end else begin
                        recs[n] = mk_rec(REC_UNKNOWN, 7'd0, pend_reg,
                                         16'(tl_reg), 16'(tc_reg), 8'd0, 1'b0);
                    end
                    n = n + 2'd1;
                end
                MODE_IDENT, MODE_NUMBER: begin
                    recs[n] = mk_rec(REC_TOKEN, kind, 8'd0, 16'(tl_reg), 16'(tc_reg),
                                     vc_reg, ovf_reg);
                    n = n + 2'd1;
                end
                MODE_STRING, MODE_ESC: begin
                    recs[n] = mk_rec(REC_OPENSTR, 7'd0, 8'd0, 16'(tl_reg), 16'(tc_reg),
                                     8'd0, 1'b0);
                    n = n + 2'd1;
                    recs[n] = mk_rec(REC_TOKEN, K_STRING, 8'd0, 16'(tl_reg),
                                     16'(tc_reg), vc_reg, ovf_reg);
                    n = n + 2'd1;
                end
                MODE_BLOCK, MODE_BLOCKGT: begin
                    recs[n] = mk_rec(REC_OPENCMT, 7'd0, 8'd0, 16'(tl_reg), 16'(tc_reg),
                                     8'd0, 1'b0);
                    n = n + 2'd1;
                end
                default: ;
            endcase
            recs[n] = mk_rec(REC_TOKEN, K_END, 8'd0, 16'(line_reg), 16'(col_reg),
                             8'd0, 1'b0);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
            pend_next = '0;
            line_next = POSITION_BITS'(1);
            col_next  = POSITION_BITS'(1);
            tl_next   = '0;
            tc_next   = '0;
            vc_next   = '0;
            kw_next   = '1;
            dec_next  = 1'b0;
            ovf_next  = 1'b0;
        end else begin
            case (mode_reg)
                MODE_PEND: begin
                    if (pend_reg == CH_TILDE && in_ch == CH_TILDE) begin
                        mode_next = MODE_LINEC;
                    end else if (pend_reg == CH_LT && in_ch == CH_LT) begin
                        mode_next = MODE_BLOCK;
                    end else if (pend_reg == CH_DOT && is_digit(in_ch)) begin
                        mode_next = MODE_NUMBER;
                        dec_next  = 1'b1;
                        vc_next   = 8'd2;
                        recs[n] = mk_rec(REC_VALUE, 7'd0, CH_DOT, 16'(tl_reg),
                                         16'(tc_reg), 8'd1, 1'b0);
                        n = n + 2'd1;
                        recs[n] = mk_rec(REC_VALUE, 7'd0, in_ch, 16'(tl_reg),
                                         16'(tc_reg), 8'd2, 1'b0);
                        n = n + 2'd1;
                    end else if (pair_kind(pend_reg, in_ch) != K_NONE) begin
                        mode_next = MODE_IDLE;
                        recs[n] = mk_rec(REC_TOKEN, pair_kind(pend_reg, in_ch), 8'd0,
                                         16'(tl_reg), 16'(tc_reg), 8'd0, 1'b0);
                        n = n + 2'd1;
                    end else begin
                        if (alone_kind(pend_reg) != K_NONE) begin
                            recs[n] = mk_rec(REC_TOKEN, alone_kind(pend_reg), 8'd0,
                                             16'(tl_reg), 16'(tc_reg), 8'd0, 1'b0);
                        end else begin
                            recs[n] = mk_rec(REC_UNKNOWN, 7'd0, pend_reg,
                                             16'(tl_reg), 16'(tc_reg), 8'd0, 1'b0);
                        end
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(in_ch) || is_digit(in_ch) || in_ch == CH_UNDER) begin
                        push_en    = 1'b1;
                        push_ident = 1'b1;
                        push_lim   = LIM_ID;
                    end else begin
                        recs[n] = mk_rec(REC_TOKEN, kind, 8'd0, 16'(tl_reg),
                                         16'(tc_reg), vc_reg, ovf_reg);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(in_ch) || in_ch == CH_DOT) begin
                        if (in_ch == CH_DOT) begin
                            dec_next = 1'b1;
                        end
                        push_en  = 1'b1;
                        push_lim = LIM_NUM;
                    end else begin
                        recs[n] = mk_rec(REC_TOKEN, kind, 8'd0, 16'(tl_reg),
                                         16'(tc_reg), vc_reg, ovf_reg);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (in_ch == CH_QUOTE) begin
                        mode_next = MODE_IDLE;
                        recs[n] = mk_rec(REC_TOKEN, K_STRING, 8'd0, 16'(tl_reg),
                                         16'(tc_reg), vc_reg, ovf_reg);
                        n = n + 2'd1;
                    end else if (in_ch == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        push_en = 1'b1;
                    end
                end
                MODE_ESC: begin
                    mode_next = MODE_STRING;
                    push_en   = 1'b1;
                    if (in_ch == "n") begin
                        push_c = 8'd10;
                    end else if (in_ch == "t") begin
                        push_c = 8'd9;
                    end
                end
                MODE_LINEC: begin
                    if (in_ch == CH_NL) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_BLOCK: begin
                    if (in_ch == CH_GT) begin
                        mode_next = MODE_BLOCKGT;
                    end
                end
                MODE_BLOCKGT: begin
                    mode_next = (in_ch == CH_GT) ? MODE_IDLE : MODE_BLOCK;
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            if (do_start) begin
                mode_next = MODE_IDLE;
                if (!is_space(in_ch)) begin
                    if (is_opchar(in_ch) || in_ch == CH_QUOTE || is_digit(in_ch) ||
                        is_alpha(in_ch) || in_ch == CH_UNDER) begin
                        tl_next  = line_reg;
                        tc_next  = col_reg;
                        vc_next  = '0;
                        dec_next = 1'b0;
                        ovf_next = 1'b0;
                        kw_next  = '1;
                        if (is_opchar(in_ch)) begin
                            mode_next = MODE_PEND;
                            pend_next = in_ch;
                        end else if (in_ch == CH_QUOTE) begin
                            mode_next = MODE_STRING;
                        end else if (is_digit(in_ch)) begin
                            mode_next = MODE_NUMBER;
                            push_en   = 1'b1;
                            push_lim  = LIM_NUM;
                        end else begin
                            mode_next  = MODE_IDENT;
                            push_en    = 1'b1;
                            push_ident = 1'b1;
                            push_lim   = LIM_ID;
                        end
                    end else if (single_kind(in_ch) != K_NONE) begin
                        recs[n] = mk_rec(REC_TOKEN, single_kind(in_ch), 8'd0,
                                         16'(line_reg), 16'(col_reg), 8'd0, 1'b0);
                        n = n + 2'd1;
                    end else begin
                        recs[n] = mk_rec(REC_UNKNOWN, 7'd0, in_ch, 16'(line_reg),
                                         16'(col_reg), 8'd0, 1'b0);
                        n = n + 2'd1;
                    end
                end
            end

            if (push_en) begin
                if ({1'b0, vc_next} + 9'd1 < push_lim) begin
                    if (push_ident) begin
                        for (int i = 0; i < KW_COUNT; i++) begin
                            if (vc_next >= {4'd0, KW_LEN[i]} ||
                                KW_TEXT[i][KW_MAX_LEN - 1 - int'(vc_next[3:0])] != push_c) begin
                                kw_next[i] = 1'b0;
                            end
                        end
                    end
                    vc_next = vc_next + 8'd1;
                    recs[n] = mk_rec(REC_VALUE, 7'd0, push_c, 16'(tl_next), 16'(tc_next),
                                     vc_next, 1'b0);
                    n = n + 2'd1;
                end else begin
                    ovf_next = 1'b1;
                end
            end

            if (in_ch == CH_NL) begin
                if (line_reg < PMAX) begin
                    line_next = line_reg + POSITION_BITS'(1);
                end
                col_next = POSITION_BITS'(1);
            end else if (col_reg < PMAX) begin
                col_next = col_reg + POSITION_BITS'(1);
            end
        end

        push_data.recs  = recs;
        push_data.count = n;
        push = accept && (n != 2'd0);
    end

endmodule

>>> src/stt_queue.sv
module stt_queue #(
    parameter int DEPTH = stt_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  stt_pkg::bundle_t push_data,
    input  logic             pop,
    output stt_pkg::bundle_t head,
    output logic             empty,
    output logic             full
);
    import stt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t mem [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign empty = cnt_reg == '0;
    assign full  = cnt_reg == CW'(DEPTH);
    assign head  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

>>> src/stt_back.sv
module stt_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  stt_pkg::bundle_t head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output stt_pkg::rec_t    out_rec,
    output logic             out_last
);
    import stt_pkg::*;

    logic [1:0] sel_reg;
    logic xfer;

    assign out_valid = !empty;
    assign out_rec   = head.recs[sel_reg];
    assign out_last  = sel_reg == head.count - 2'd1;
    assign xfer      = out_valid && out_ready;
    assign pop       = xfer && out_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 2'd0;
        end else if (xfer) begin
            sel_reg <= out_last ? 2'd0 : sel_reg + 2'd1;
        end
    end

    a_sel_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> sel_reg < head.count)
        else $error("record select beyond bundle");

    a_bundle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && !out_last |=> out_valid && sel_reg == $past(sel_reg) + 2'd1)
        else $error("bundle dropped before its last record");

    a_trunc_token_only: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_rec.trunc |-> out_rec.rtype == REC_TOKEN)
        else $error("truncated flag on non-token record");

endmodule

>>> src/source_text_tokenizer.sv
// Streaming source tokenizer.
// Input transfer: s_ch carries one source byte, or s_end_of_source marks the
// end of text (s_ch ignored); the end mark flushes open tokens, emits the end
// token and returns the lexer to its start state for the next text.
// Output transfer: one record per cycle on m_* while m_ready is high; m_last
// flags the final record caused by one input byte. Bytes that give no record
// (whitespace, comments, opening quote, pending operator) produce no output.
// Throughput: one byte per cycle while each byte yields at most one record
// and m_ready stays high; a byte giving two or three records holds its bundle
// at the queue head while the output drains them one record per cycle.
// Records are registered: a byte's bundle enters the queue when the byte is
// accepted. The lexer classifies a byte in the cycle it is accepted and writes
// its records as one bundle into a two-entry queue; s_ready drops only when
// the queue is full, so a stalled receiver backs up into the source after two
// bundles. Reset clears the lexer state and empties the queue.
module source_text_tokenizer #(
    parameter int STRING_LIMIT  = stt_pkg::STRING_LIMIT_DEF,
    parameter int IDENT_LIMIT   = stt_pkg::IDENT_LIMIT_DEF,
    parameter int NUMBER_LIMIT  = stt_pkg::NUMBER_LIMIT_DEF,
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_source,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_record_type,
    output logic [6:0]  m_token_kind,
    output logic [7:0]  m_value_char,
    output logic [15:0] m_start_line,
    output logic [15:0] m_start_column,
    output logic [7:0]  m_value_length,
    output logic        m_truncated,
    output logic        m_last
);
    import stt_pkg::*;

    logic    push, pop, empty, full;
    bundle_t push_data, head;
    rec_t    rec;

    assign s_ready = !full;

    stt_front #(
        .STRING_LIMIT(STRING_LIMIT),
        .IDENT_LIMIT(IDENT_LIMIT),
        .NUMBER_LIMIT(NUMBER_LIMIT),
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(s_valid),
        .in_ch(s_ch),
        .in_eos(s_end_of_source),
        .space_ok(!full),
        .push(push),
        .push_data(push_data)
    );

    stt_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .push_data(push_data),
        .pop(pop),
        .head(head),
        .empty(empty),
        .full(full)
    );

    stt_back u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .head(head),
        .empty(empty),
        .pop(pop),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_rec(rec),
        .out_last(m_last)
    );

    assign m_record_type  = rec.rtype;
    assign m_token_kind   = rec.kind;
    assign m_value_char   = rec.vchar;
    assign m_start_line   = rec.line;
    assign m_start_column = rec.col;
    assign m_value_length = rec.len;
    assign m_truncated    = rec.trunc;

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    import stt_pkg::*;

    localparam int NUM_LIMIT = 64;
    localparam int ID_LIMIT  = 64;
    localparam int STR_LIMIT = 256;
    localparam int POS_SAT   = 65535;

    // operator kinds, dense in the order the block numbers them
    typedef enum logic [6:0] {
        OP_ASSIGN = 7'd44, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE,
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_ARROW, OP_BACKARROW,
        OP_AND, OP_OR, OP_NOT, OP_DOT, OP_COMMA, OP_COLON, OP_SEMI,
        OP_LBRACE, OP_RBRACE, OP_LPAREN, OP_RPAREN, OP_LBRACK, OP_RBRACK
    } op_kind_t;

    typedef struct {
        logic [2:0]  rtype;
        logic [6:0]  kind;
        logic [7:0]  vch;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  len;
        logic        trunc;
        logic        last;
    } tok_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch = 8'd0;
    logic        s_end_of_source = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_record_type;
    logic [6:0]  m_token_kind;
    logic [7:0]  m_value_char;
    logic [15:0] m_start_line;
    logic [15:0] m_start_column;
    logic [7:0]  m_value_length;
    logic        m_truncated;
    logic        m_last;

    source_text_tokenizer dut (.*);

    always #10 aclk = ~aclk;

    string kw_words[KW_COUNT] = '{
        "correct", "incorrect", "emp", "", "core", "firm", "craft",
        "returns", "if", "altif", "else", "flow", "during", "frame", "boot",
        "spawn", "open", "hidden", "consistof", "resc", "attack", "spark", "sync",
        "bind", "ref", "ptr", "raw", "rise", "drop", "and", "or", "not", "rec",
        "coll", "int", "dnum", "txt", "fetch", "stamp", "grab"
    };

    // lexer shadow state
    lex_mode_t   mode;
    logic [7:0]  pend;
    int          cur_line, cur_col, tok_line, tok_col, vcount;
    logic        dec_seen, ovf_seen;
    byte unsigned word_q[$];

    tok_rec_t    item_recs[$];
    tok_rec_t    token_records_due[$];
    int          errors = 0;
    int          items_sent = 0;
    int          records_seen = 0;
    int          burst_left = 0;
    logic [7:0]  stall_phase = 8'd0;

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alp(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void clear_lexer();
        mode = MODE_IDLE;
        pend = 8'd0;
        cur_line = 1;
        cur_col = 1;
        tok_line = 0;
        tok_col = 0;
        vcount = 0;
        dec_seen = 0;
        ovf_seen = 0;
        word_q.delete();
    endfunction

    function void put(logic [2:0] rt, logic [6:0] kind, logic [7:0] vc, int line,
                      int col, int len, logic tr);
        tok_rec_t r;
        r.rtype = rt;
        r.kind = kind;
        r.vch = vc;
        r.line = line[15:0];
        r.col = col[15:0];
        r.len = len[7:0];
        r.trunc = tr;
        r.last = 1'b0;
        item_recs.push_back(r);
    endfunction

    function void put_token(logic [6:0] kind, int len, logic tr);
        put(REC_TOKEN, kind, 8'd0, tok_line, tok_col, len, tr);
    endfunction

    function void open_token(lex_mode_t m);
        tok_line = cur_line;
        tok_col = cur_col;
        vcount = 0;
        dec_seen = 0;
        ovf_seen = 0;
        word_q.delete();
        mode = m;
    endfunction

    function void add_value(logic [7:0] c, int limit);
        if (vcount + 1 < limit) begin
            if (mode == MODE_IDENT)
                word_q.push_back(c);
            vcount++;
            put(REC_VALUE, 7'd0, c, tok_line, tok_col, vcount, 1'b0);
        end else begin
            ovf_seen = 1'b1;
        end
    endfunction

    function void close_word();
        logic [6:0] kind;
        bit hit;
        if (mode == MODE_IDENT) begin
            kind = K_IDENT;
            if (!ovf_seen) begin
                for (int i = KW_COUNT - 1; i >= 0; i--) begin
                    hit = kw_words[i].len() == word_q.size();
                    for (int j = 0; hit && j < word_q.size(); j++)
                        if (kw_words[i][j] != word_q[j])
                            hit = 0;
                    if (hit)
                        kind = K_KW0 + 7'(i);
                end
            end
        end else begin
            kind = dec_seen ? K_DNUM : K_INT;
        end
        put_token(kind, vcount, ovf_seen);
        mode = MODE_IDLE;
    endfunction

    function automatic logic [6:0] lone_op(logic [7:0] c);
        case (c)
            "*": return OP_MUL;
            "/": return OP_DIV;
            "%": return OP_MOD;
            ",": return OP_COMMA;
            ":": return OP_COLON;
            ";": return OP_SEMI;
            "{": return OP_LBRACE;
            "}": return OP_RBRACE;
            "(": return OP_LPAREN;
            ")": return OP_RPAREN;
            "[": return OP_LBRACK;
            "]": return OP_RBRACK;
            default: return K_NONE;
        endcase
    endfunction

    function void begin_char(logic [7:0] c);
        mode = MODE_IDLE;
        if (is_blank(c))
            return;
        if (c inside {CH_TILDE, CH_LT, "+", "-", "=", "!", CH_GT, "&", "|", CH_DOT}) begin
            open_token(MODE_PEND);
            pend = c;
        end else if (c == CH_QUOTE) begin
            open_token(MODE_STRING);
        end else if (is_dig(c)) begin
            open_token(MODE_NUMBER);
            add_value(c, NUM_LIMIT);
        end else if (is_alp(c)) begin
            open_token(MODE_IDENT);
            add_value(c, ID_LIMIT);
        end else if (lone_op(c) != K_NONE) begin
            put(REC_TOKEN, lone_op(c), 8'd0, cur_line, cur_col, 0, 1'b0);
        end else begin
            put(REC_UNKNOWN, 7'd0, c, cur_line, cur_col, 0, 1'b0);
        end
    endfunction

    function void flush_pending();
        mode = MODE_IDLE;
        case (pend)
            CH_LT:  put_token(OP_LT, 0, 1'b0);
            CH_GT:  put_token(OP_GT, 0, 1'b0);
            "=":    put_token(OP_ASSIGN, 0, 1'b0);
            "!":    put_token(OP_NOT, 0, 1'b0);
            "+":    put_token(OP_ADD, 0, 1'b0);
            "-":    put_token(OP_SUB, 0, 1'b0);
            CH_DOT: put_token(OP_DOT, 0, 1'b0);
            default: put(REC_UNKNOWN, 7'd0, pend, tok_line, tok_col, 0, 1'b0);
        endcase
    endfunction

    function void pending_next(logic [7:0] c);
        logic [6:0] pair;
        if (pend == CH_TILDE && c == CH_TILDE) begin
            mode = MODE_LINEC;
            return;
        end
        if (pend == CH_LT && c == CH_LT) begin
            mode = MODE_BLOCK;
            return;
        end
        if (pend == CH_DOT && is_dig(c)) begin
            mode = MODE_NUMBER;
            dec_seen = 1'b1;
            add_value(CH_DOT, NUM_LIMIT);
            add_value(c, NUM_LIMIT);
            return;
        end
        pair = K_NONE;
        if (pend == CH_LT && c == "=") pair = OP_LE;
        else if (pend == CH_GT && c == "=") pair = OP_GE;
        else if (pend == "=" && c == "=") pair = OP_EQ;
        else if (pend == "!" && c == "=") pair = OP_NE;
        else if (pend == "+" && c == CH_GT) pair = OP_ARROW;
        else if (pend == "-" && c == CH_LT) pair = OP_BACKARROW;
        else if (pend == "&" && c == "&") pair = OP_AND;
        else if (pend == "|" && c == "|") pair = OP_OR;
        if (pair != K_NONE) begin
            put_token(pair, 0, 1'b0);
            mode = MODE_IDLE;
            return;
        end
        flush_pending();
        begin_char(c);
    endfunction

    // expected records for one accepted input transfer
    function void lex_byte(logic [7:0] c, logic eos);
        item_recs.delete();
        if (eos) begin
            case (mode)
                MODE_PEND: flush_pending();
                MODE_IDENT, MODE_NUMBER: close_word();
                MODE_STRING, MODE_ESC: begin
                    put(REC_OPENSTR, 7'd0, 8'd0, tok_line, tok_col, 0, 1'b0);
                    put_token(K_STRING, vcount, ovf_seen);
                end
                MODE_BLOCK, MODE_BLOCKGT:
                    put(REC_OPENCMT, 7'd0, 8'd0, tok_line, tok_col, 0, 1'b0);
                default: ;
            endcase
            put(REC_TOKEN, K_END, 8'd0, cur_line, cur_col, 0, 1'b0);
            clear_lexer();
        end else begin
            case (mode)
                MODE_PEND: pending_next(c);
                MODE_IDENT:
                    if (is_alp(c) || is_dig(c)) add_value(c, ID_LIMIT);
                    else begin
                        close_word();
                        begin_char(c);
                    end
                MODE_NUMBER:
                    if (is_dig(c) || c == CH_DOT) begin
                        if (c == CH_DOT) dec_seen = 1'b1;
                        add_value(c, NUM_LIMIT);
                    end else begin
                        close_word();
                        begin_char(c);
                    end
                MODE_STRING:
                    if (c == CH_QUOTE) begin
                        put_token(K_STRING, vcount, ovf_seen);
                        mode = MODE_IDLE;
                    end else if (c == CH_BSLASH) begin
                        mode = MODE_ESC;
                    end else begin
                        add_value(c, STR_LIMIT);
                    end
                MODE_ESC: begin
                    mode = MODE_STRING;
                    add_value(c == "n" ? CH_NL : (c == "t" ? 8'd9 : c), STR_LIMIT);
                end
                MODE_LINEC: if (c == CH_NL) mode = MODE_IDLE;
                MODE_BLOCK: if (c == CH_GT) mode = MODE_BLOCKGT;
                MODE_BLOCKGT: mode = (c == CH_GT) ? MODE_IDLE : MODE_BLOCK;
                default: begin_char(c);
            endcase
            if (c == CH_NL) begin
                if (cur_line < POS_SAT) cur_line++;
                cur_col = 1;
            end else if (cur_col < POS_SAT) begin
                cur_col++;
            end
        end
        if (item_recs.size() > 0)
            item_recs[item_recs.size() - 1].last = 1'b1;
        foreach (item_recs[i])
            token_records_due.push_back(item_recs[i]);
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eos);
        s_ch <= c;
        s_end_of_source <= eos;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        lex_byte(c, eos);
        items_sent++;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], 1'b0);
    endtask

    task automatic send_end();
        send_byte($urandom_range(0, 255), 1'b1);
    endtask

    task automatic drain();
        while (token_records_due.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // receiver: free-running stretches alternate with random stalls
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 8'd1;
        m_ready <= stall_phase[6] ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        tok_rec_t e;
        if (aresetn && m_valid && m_ready) begin
            records_seen++;
            if (token_records_due.size() == 0) begin
                $error("record with nothing expected (type %0d kind %0d)",
                       m_record_type, m_token_kind);
                errors++;
            end else begin
                e = token_records_due.pop_front();
                check_field("record_type", e.rtype, m_record_type);
                check_field("token_kind", e.kind, m_token_kind);
                check_field("value_char", e.vch, m_value_char);
                check_field("start_line", e.line, m_start_line);
                check_field("start_column", e.col, m_start_column);
                check_field("value_length", e.len, m_value_length);
                check_field("truncated", e.trunc, m_truncated);
                check_field("last", e.last, m_last);
            end
        end
    end

    task automatic test_operators_and_literals();
        send_text("if x_1 == 3.5 <<c>>>~~note\n\"a\\n\\t\\\"\\\\b\" .5 . 12.3.4\n");
        send_text("+> -< && || <= >= != ! = < > + - * / % , : ; { } ( ) [ ] ~ & |");
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte("@", 1'b0);
        send_text("\tA\r\v\f~");
        send_end();
    endtask

    task automatic test_keywords();
        foreach (kw_words[i])
            send_text({kw_words[i], " ", kw_words[i], "x "});
        send_text("Int IF");
        send_end();
    endtask

    task automatic test_open_constructs();
        send_text("\"ab\\");
        send_end();
        send_text("\"q");
        send_end();
        send_text("<<x>");
        send_end();
        send_text("ab");
        send_end();
        send_text("7.");
        send_end();
        send_text("<");
        send_end();
        send_text("&");
        send_end();
        send_end();
    endtask

    task automatic test_truncation();
        repeat (70) send_byte("k", 1'b0);
        send_text(" ");
        send_text("if");
        repeat (62) send_byte("z", 1'b0);
        send_text(" ");
        repeat (70) send_byte("9", 1'b0);
        send_text(" \"");
        repeat (258) send_byte($urandom_range("a", "z"), 1'b0);
        send_text("\\n\" \"x");
        repeat (260) send_byte("y", 1'b0);
        send_end();
    endtask

    task automatic send_fragment();
        string ops[] = '{"==", "!=", "<=", ">=", "+>", "-<", "&&", "||", "=", "<",
                         ">", "+", "-", "!", ".", "*", "/", "%", ",", ":", ";",
                         "{", "}", "(", ")", "[", "]", "~", "&", "|"};
        string escs[] = '{"\\n", "\\t", "\\\"", "\\\\", "\\q"};
        case ($urandom_range(0, 11))
            0: send_text(kw_words[$urandom_range(0, KW_COUNT - 1)]);
            1, 2: begin
                send_byte($urandom_range(0, 1) ? $urandom_range("a", "z") : CH_UNDER, 1'b0);
                repeat ($urandom_range(0, 6))
                    send_byte($urandom_range(0, 2) == 0 ? $urandom_range("0", "9")
                                                        : $urandom_range("A", "z"), 1'b0);
            end
            3: repeat ($urandom_range(1, 5))
                send_byte($urandom_range(0, 4) == 0 ? CH_DOT : $urandom_range("0", "9"), 1'b0);
            4: begin
                send_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 5))
                    if ($urandom_range(0, 3) == 0) send_text(escs[$urandom_range(0, 4)]);
                    else send_byte($urandom_range(32, 126), 1'b0);
                if ($urandom_range(0, 7) != 0) send_byte(CH_QUOTE, 1'b0);
            end
            5, 6: send_text(ops[$urandom_range(0, ops.size() - 1)]);
            7: send_text($urandom_range(0, 1) ? "~~ c\n" : "<< b > >>");
            8: send_byte($urandom_range(0, 255), 1'b0);
            9: send_byte($urandom_range(0, 1) ? CH_NL : 8'd9, 1'b0);
            10: if ($urandom_range(0, 5) == 0) send_end();
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0)
            send_byte(" ", 1'b0);
    endtask

    task automatic test_random_text();
        int start_items;
        start_items = items_sent;
        while (items_sent - start_items < 220)
            send_fragment();
        send_end();
    endtask

    initial begin
        kw_words[3] = {"ri", "ven"};
        clear_lexer();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_operators_and_literals();
        test_keywords();
        test_open_constructs();
        test_truncation();
        test_random_text();
        s_valid <= 1'b0;
        drain();
        $display("Covered operators, keywords, literals, comments, truncation, open constructs");
        $display("and random text: %0d transfers in, %0d records out.",
                 items_sent, records_seen);
        if (errors == 0 && token_records_due.size() == 0)
            $display("PASS source_text_tokenizer");
        else
            $display("FAIL source_text_tokenizer");
        $finish;
    end

    initial begin
        #40000000;
        $display("FAIL source_text_tokenizer");
        $finish;
    end

endmodule
